>>> rtl/icgd_pkg.sv
// Shared constants, types and state codes for the coverage gap detector.
package icgd_pkg;

    localparam int MAX_EVENTS  = 512;
    localparam int POS_BITS    = 24;
    localparam int DUP_DIVISOR = 50;

    localparam int FIELD_W   = 24;
    localparam int FLANK_W   = 16;
    localparam int MINCOV_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W    = $clog2(MAX_EVENTS);
    localparam int CNT_W     = $clog2(MAX_EVENTS + 1);
    localparam int EV_W      = POS_BITS + 1;
    localparam int DUP_W     = $clog2(DUP_DIVISOR + 1);
    localparam int PROD_W    = FIELD_W + DUP_W;
    localparam int CMP_W     = (CNT_W > MINCOV_W) ? CNT_W : MINCOV_W;
    localparam int IN_DATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] REG_FLANK_LEN    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COVERAGE = 1'd1;

    localparam logic [FLANK_W-1:0]  FLANK_RST  = 16'd256;
    localparam logic [MINCOV_W-1:0] MINCOV_RST = 8'd2;

    localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
    localparam logic [1:0] STATUS_CIS     = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DEC,
        S_WR_END,
        S_SORT_RD,
        S_SORT_LD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SWEEP_RD,
        S_SWEEP,
        S_SWEEP_END,
        S_DONE
    } icgd_state_t;

endpackage

>>> rtl/interval_coverage_gap_detect_core.sv
// Coverage gap detector: collects alignment intervals of a read, sorts and sweeps them.
//
// Input words arrive on the s_axis channel, one alignment per word; tlast marks the
// final word of a read. Only a last word produces a result on m_axis (tdata bit 0
// is_chimeric, bit 1 overflow); other words produce nothing.
// A non-last word passes through register, multiply, decide with the start event
// write, and an optional end event write into the event memory. A last word then sorts
// the N stored events by insertion sort in the single-port-read event memory (read,
// load, compare with one shift per event moved, put), then sweeps them at one event
// per cycle.
// The event memory has one write and one registered read port; every sort and
// sweep step is bounded by that read port.
// The result sits in an output register; the next read's words are taken while it
// waits, and a second result waits in the final state until m_axis_tready frees it.
// Reset clears the event count, overflow flag, output and configuration registers
// (flank_len 256, min_coverage 2); no memory clearing pass is needed.
// Configuration writes via cfg_we/cfg_addr/cfg_wdata take effect on the next cycle.
module interval_coverage_gap_detect_core
    import icgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // read_len, aln_start, aln_end, other_len, pair_status, in_graph, zero fill
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // has_alignment
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // is_chimeric, overflow, zero fill
    output logic [7:0]           m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [FLANK_W-1:0]   cfg_wdata
);

    icgd_state_t state_reg, state_next;

    logic [FLANK_W-1:0]  flank_reg;
    logic [MINCOV_W-1:0] mincov_reg;

    logic [FIELD_W-1:0] rl_reg, st_reg, en_reg, ol_reg;
    logic [1:0]         ps_reg;
    logic               ig_reg, has_reg, last_reg;

    logic [PROD_W-1:0]  diff50_reg, unal50_reg;
    logic               ovok_reg, eneg_reg, counted_reg;
    logic [FIELD_W:0]   s_reg;
    logic [FIELD_W-1:0] e_reg;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic [EV_W-1:0]     v_reg, v_next;
    logic [CNT_W-1:0]    cov_reg, cov_next;
    logic [POS_BITS-1:0] prev_reg, prev_next;
    logic                gap_reg, gap_next;
    logic [CNT_W-1:0]    p_reg, p_next;

    logic out_valid_reg, out_valid_next;
    logic out_chim_reg, out_chim_next;
    logic out_ovf_reg, out_ovf_next;

    logic [EV_W-1:0]   mem [MAX_EVENTS];
    logic [EV_W-1:0]   rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [EV_W-1:0]   mem_wdata;

    logic               in_acc;
    logic [FIELD_W-1:0] diff, ov, unal;
    logic               dup, want, fits;
    logic [CNT_W-1:0]   cnt_plus1;
    logic [CNT_W:0]     cnt_plus2;
    logic [POS_BITS-1:0] rd_pos;
    logic               cov_low, out_free;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_ovf_reg, out_chim_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign diff = (rl_reg > ol_reg) ? (rl_reg - ol_reg) : (ol_reg - rl_reg);
    assign ov   = en_reg - st_reg;
    assign unal = rl_reg - ov;

    assign dup  = (diff50_reg <= PROD_W'(rl_reg)) && (diff50_reg <= PROD_W'(ol_reg))
                  && ovok_reg && (unal50_reg <= PROD_W'(rl_reg));
    assign want = counted_reg && !dup && !eneg_reg && (s_reg < {1'b0, e_reg});
    assign cnt_plus1 = cnt_reg + CNT_W'(1);
    assign cnt_plus2 = {1'b0, cnt_reg} + (CNT_W+1)'(2);
    assign fits      = (cnt_plus2 <= (CNT_W+1)'(MAX_EVENTS));

    assign rd_pos  = rdata_reg[EV_W-1:1];
    assign cov_low = CMP_W'(cov_reg) < CMP_W'(mincov_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flank_reg  <= FLANK_RST;
            mincov_reg <= MINCOV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FLANK_LEN:    flank_reg  <= cfg_wdata;
                REG_MIN_COVERAGE: mincov_reg <= cfg_wdata[MINCOV_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rl_reg   <= s_axis_tdata[23:0];
            st_reg   <= s_axis_tdata[47:24];
            en_reg   <= s_axis_tdata[71:48];
            ol_reg   <= s_axis_tdata[95:72];
            ps_reg   <= s_axis_tdata[97:96];
            ig_reg   <= s_axis_tdata[98];
            has_reg  <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == S_MUL)
        begin
            diff50_reg  <= PROD_W'(diff) * PROD_W'(DUP_DIVISOR);
            unal50_reg  <= PROD_W'(unal) * PROD_W'(DUP_DIVISOR);
            ovok_reg    <= (en_reg >= st_reg) && (ov <= rl_reg);
            counted_reg <= has_reg && ((ps_reg == STATUS_CIS)
                           || ((ps_reg == STATUS_UNKNOWN) && ig_reg));
            s_reg       <= {1'b0, st_reg}
                           + ((st_reg != '0) ? (FIELD_W+1)'(flank_reg) : '0);
            e_reg       <= (en_reg < rl_reg) ? (en_reg - FIELD_W'(flank_reg)) : en_reg;
            eneg_reg    <= (en_reg < rl_reg) && (en_reg < FIELD_W'(flank_reg));
        end
        v_reg    <= v_next;
        j_reg    <= j_next;
        prev_reg <= prev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            cov_reg       <= '0;
            gap_reg       <= 1'b0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_chim_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            cov_reg       <= cov_next;
            gap_reg       <= gap_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
            out_chim_reg  <= out_chim_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (want && fits)
                begin
                    state_next = S_WR_END;
                end
                else if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SORT_RD;
                end
            end
            S_WR_END:
            begin
                state_next = last_reg ? S_SORT_RD : S_IDLE;
            end
            S_SORT_RD:
            begin
                state_next = (i_reg >= cnt_reg) ? S_SWEEP_RD : S_SORT_LD;
            end
            S_SORT_LD:
            begin
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (!(rdata_reg > v_reg) || (j_reg == ADDR_W'(1)))
                begin
                    state_next = S_SORT_PUT;
                end
            end
            S_SORT_PUT:
            begin
                state_next = S_SORT_RD;
            end
            S_SWEEP_RD:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if ((p_reg + CNT_W'(1)) >= cnt_reg)
                begin
                    state_next = S_SWEEP_END;
                end
            end
            S_SWEEP_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[ADDR_W-1:0];
        mem_wdata      = v_reg;
        mem_raddr      = '0;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        v_next         = v_reg;
        cov_next       = cov_reg;
        prev_next      = prev_reg;
        gap_next       = gap_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_chim_next  = out_chim_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            S_DEC:
            begin
                i_next   = CNT_W'(1);
                gap_next = 1'b1;
                if (want && fits)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[ADDR_W-1:0];
                    mem_wdata = {s_reg[POS_BITS-1:0], 1'b1};
                end
                else if (want)
                begin
                    ovf_next = 1'b1;
                end
            end
            S_WR_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_plus1[ADDR_W-1:0];
                mem_wdata = {e_reg[POS_BITS-1:0], 1'b0};
                cnt_next  = cnt_plus2[CNT_W-1:0];
            end
            S_SORT_RD:
            begin
                mem_raddr = i_reg[ADDR_W-1:0];
            end
            S_SORT_LD:
            begin
                v_next    = rdata_reg;
                j_next    = i_reg[ADDR_W-1:0];
                mem_raddr = i_reg[ADDR_W-1:0] - ADDR_W'(1);
            end
            S_SORT_CMP:
            begin
                if (rdata_reg > v_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = rdata_reg;
                    j_next    = j_reg - ADDR_W'(1);
                    mem_raddr = j_reg - ADDR_W'(2);
                end
            end
            S_SORT_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = v_reg;
                i_next    = i_reg + CNT_W'(1);
            end
            S_SWEEP_RD:
            begin
                mem_raddr = '0;
                p_next    = '0;
                cov_next  = '0;
                prev_next = '0;
                gap_next  = 1'b0;
            end
            S_SWEEP:
            begin
                if ((rd_pos > prev_reg) && cov_low)
                begin
                    gap_next = 1'b1;
                end
                cov_next  = rdata_reg[0] ? (cov_reg + CNT_W'(1)) : (cov_reg - CNT_W'(1));
                prev_next = rd_pos;
                p_next    = p_reg + CNT_W'(1);
                mem_raddr = p_next[ADDR_W-1:0];
            end
            S_SWEEP_END:
            begin
                if ((FIELD_W'(prev_reg) < rl_reg) && cov_low)
                begin
                    gap_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_chim_next  = gap_reg;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_EVENTS))
        else $error("event count beyond store depth");

    a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] == 1'b0)
        else $error("event count odd");

    a_sort_j: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT_CMP) |-> (j_reg != '0))
        else $error("insertion index reached zero in compare");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (cnt_reg == '0) && !ovf_reg && out_valid_reg)
        else $error("read state not cleared after result");

endmodule

>>> sim/interval_coverage_gap_detect_core_test.sv
// Self-checking testbench for the coverage gap detector core.
`timescale 1ns / 100ps

module interval_coverage_gap_detect_core_test
    import icgd_pkg::*;
();

    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] STATUS_TRANS = 2'd2;
    localparam logic [1:0] STATUS_SPARE = 2'd3;

    class coverage_predictor;
        logic [FLANK_W-1:0]  flank;
        logic [MINCOV_W-1:0] min_cov;
        logic [EV_W-1:0]     events[$];
        bit                  ovf_seen;
        bit [1:0]            verdict_q[$];
        int                  mismatches;
        int                  verdicts;

        function new();
            flank = FLANK_RST;
            min_cov = MINCOV_RST;
            ovf_seen = 0;
            mismatches = 0;
            verdicts = 0;
        endfunction

        function void note_word(logic [23:0] rl, bit has, logic [23:0] st, logic [23:0] en,
                                logic [23:0] ol, logic [1:0] ps, bit ig, bit last);
            longint diff, thr_r, thr_o, s, e, cov;
            longint prev, pos;
            bit dup, chim;
            if (has && (ps == STATUS_CIS || (ps == STATUS_UNKNOWN && ig)))
            begin
                diff = (rl > ol) ? rl - ol : ol - rl;
                thr_r = rl / DUP_DIVISOR;
                thr_o = ol / DUP_DIVISOR;
                dup = 0;
                if (diff <= thr_r && diff <= thr_o && en >= st)
                    if (longint'(en - st) <= rl && rl - longint'(en - st) <= thr_r)
                        dup = 1;
                if (!dup)
                begin
                    s = st;
                    e = en;
                    if (s > 0)
                        s += flank;
                    if (e < rl)
                        e -= flank;
                    if (s < e)
                    begin
                        if (events.size() + 2 > MAX_EVENTS)
                            ovf_seen = 1;
                        else
                        begin
                            events.insert(events.size(), {s[23:0], 1'b1});
                            events.insert(events.size(), {e[23:0], 1'b0});
                        end
                    end
                end
            end
            if (!last)
                return;
            if (events.size() == 0)
                chim = 1;
            else
            begin
                events.sort();
                chim = 0;
                cov = 0;
                prev = 0;
                foreach (events[i])
                begin
                    pos = events[i][EV_W-1:1];
                    if (!chim && pos > prev && cov < min_cov)
                        chim = 1;
                    cov += events[i][0] ? 1 : -1;
                    prev = pos;
                end
                if (!chim)
                    chim = prev < rl && cov < min_cov;
            end
            verdict_q.insert(verdict_q.size(), {ovf_seen, chim});
            events.delete();
            ovf_seen = 0;
        endfunction

        function void check_verdict(logic [7:0] word);
            bit [1:0] exp_v;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            exp_v = verdict_q.pop_front();
            verdicts++;
            if (word[0] !== exp_v[0] || word[1] !== exp_v[1] || word[7:2] !== 6'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected chimeric=%b overflow=%b, got tdata=%b",
                             verdicts, exp_v[0], exp_v[1], word);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [FLANK_W-1:0]   cfg_wdata;

    coverage_predictor pred;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  words_sent;
    int  reads_sent;
    longint cycles = 0;

    interval_coverage_gap_detect_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL interval_coverage_gap_detect_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pred.check_verdict(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic send_word(logic [23:0] rl, bit has, logic [23:0] st, logic [23:0] en,
                             logic [23:0] ol, logic [1:0] ps, bit ig, bit last);
        if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, ig, ps, ol, en, st, rl};
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred.note_word(rl, has, st, en, ol, ps, ig, last);
        words_sent++;
        if (last)
            reads_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pred.verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FLANK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FLANK_LEN)
            pred.flank = val;
        else
            pred.min_cov = val[MINCOV_W-1:0];
        @(posedge clk);
    endtask

    task automatic send_directed();
        // read without alignment, then pass/fail coverage shapes
        send_word(24'd5000, 0, 24'd0, 24'd0, 24'd5000, STATUS_CIS, 0, 1);
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd9000, STATUS_CIS, 0, 0);
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd8000, STATUS_UNKNOWN, 1, 1);
        // duplicate dropped, trans and spare status ignored, unknown without graph
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd9000, STATUS_CIS, 0, 0);
        send_word(24'd5000, 1, 24'd10, 24'd4990, 24'd5050, STATUS_CIS, 1, 0);
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd7000, STATUS_TRANS, 1, 0);
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd7000, STATUS_SPARE, 1, 0);
        send_word(24'd5000, 1, 24'd0, 24'd5000, 24'd7000, STATUS_UNKNOWN, 0, 1);
        // start after end, end past read length, shifting read length
        send_word(24'd4000, 1, 24'd3000, 24'd100, 24'd9000, STATUS_CIS, 0, 0);
        send_word(24'd4000, 1, 24'd0, 24'd6000, 24'd9000, STATUS_CIS, 0, 0);
        send_word(24'd3000, 1, 24'd0, 24'd7000, 24'd9100, STATUS_CIS, 0, 0);
        send_word(24'd6000, 1, 24'd500, 24'd6000, 24'd9200, STATUS_CIS, 0, 1);
        // field extremes
        send_word(24'hFFFFFF, 1, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, STATUS_CIS, 1, 0);
        send_word(24'hFFFFFF, 1, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, STATUS_CIS, 1, 0);
        send_word(24'hFFFFFF, 1, 24'h000001, 24'hFFFFFE, 24'h000000, STATUS_CIS, 0, 0);
        send_word(24'hFFFFFF, 1, 24'h000000, 24'hFFFFFF, 24'h123456, STATUS_CIS, 0, 1);
        send_word(24'd0, 1, 24'd0, 24'd0, 24'd0, STATUS_CIS, 1, 1);
        send_word(24'd0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, STATUS_SPARE, 1, 1);
    endtask

    task automatic send_reads(int n_words);
        logic [23:0] rl, st, en, ol;
        logic [1:0]  ps;
        int k, flav;
        int stop;
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            flav = $urandom_range(0, 99);
            k = $urandom_range(1, 7);
            rl = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                 : 24'($urandom_range(600, 60000));
            for (int i = 0; i < k; i++)
            begin
                if (flav < 85)
                begin
                    st = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(0, rl / 2));
                    en = ($urandom_range(0, 2) == 0) ? rl
                         : 24'(st + $urandom_range(0, rl - st + rl / 8));
                    ol = ($urandom_range(0, 3) == 0) ? 24'(rl + $urandom_range(0, rl / 40))
                         : 24'($urandom());
                    ps = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : STATUS_CIS;
                    send_word(rl, $urandom_range(0, 15) != 0, st, en, ol, ps,
                              1'($urandom_range(0, 1)), i == k - 1);
                end
                else
                    send_word(24'($urandom()), 1'($urandom_range(0, 1)), 24'($urandom()),
                              24'($urandom()), 24'($urandom()), 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), i == k - 1);
            end
        end
    endtask

    task automatic send_overflow_read();
        for (int i = 0; i < 260; i++)
            send_word(24'd4000, 1, 24'($urandom_range(0, 1500)), 24'($urandom_range(2500, 4000)),
                      24'd9000, STATUS_CIS, 0, i == 259);
    endtask

    initial
    begin
        pred = new();
        words_sent = 0;
        reads_sent = 0;
        snd_idle_pct = 15;
        rcv_idle_pct = 79;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_reads(230);
        drain();
        write_reg(REG_FLANK_LEN, 16'd0);
        write_reg(REG_MIN_COVERAGE, 16'd1);
        send_directed();
        send_reads(230);
        drain();

        snd_idle_pct = 79;
        rcv_idle_pct = 15;
        write_reg(REG_FLANK_LEN, 16'hFFFF);
        write_reg(REG_MIN_COVERAGE, 16'd255);
        send_reads(200);
        drain();
        write_reg(REG_FLANK_LEN, 16'($urandom_range(0, 400)));
        write_reg(REG_MIN_COVERAGE, 16'd3);
        send_overflow_read();
        send_reads(200);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_FLANK_LEN, 16'($urandom_range(0, 2000)));
        write_reg(REG_MIN_COVERAGE, 16'($urandom_range(1, 4)));
        send_reads(220);
        drain();
        write_reg(REG_FLANK_LEN, 16'd256);
        write_reg(REG_MIN_COVERAGE, 16'd2);
        send_reads(220);
        drain();

        $display("Covered %0d words in %0d reads over six register settings,", words_sent,
                 reads_sent);
        $display("including an overflowing read; %0d results checked, %0d mismatches.",
                 pred.verdicts, pred.mismatches);
        if (pred.mismatches == 0 && pred.verdict_q.size() == 0)
            $display("PASS interval_coverage_gap_detect_core");
        else
            $display("FAIL interval_coverage_gap_detect_core");
        $finish;
    end

endmodule
